/* hdl/range_add_range_sum_tree_top_assert.svh */
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top_assert.svh
// assertion macros shared by the range add / range sum block
// ----------------------------------------------------------------------------
`ifndef RANGE_ADD_RANGE_SUM_TREE_TOP_ASSERT_SVH
`define RANGE_ADD_RANGE_SUM_TREE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RAST_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RAST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rast_pkg.sv */
// ----------------------------------------------------------------------------
// rast_pkg
// shared constants and types of the range add / range sum block
// ----------------------------------------------------------------------------
package rast_pkg;

    localparam int ENTRIES_DEFAULT = 1024;
    localparam int IDX_W           = 10;
    localparam int DATA_W          = 32;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUM = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  left;
        logic [IDX_W-1:0]  right;
        logic [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic              has_result;
        logic [DATA_W-1:0] sum;
    } t_done;

endpackage

/* hdl/rast_ram.sv */
// ----------------------------------------------------------------------------
// rast_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hdl/rast_core.sv */
// ----------------------------------------------------------------------------
// rast_core
// sequencer over two binary indexed trees sharing one multiplier
// ----------------------------------------------------------------------------
module rast_core import rast_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_req  i_req,
    input  logic  i_out_free,
    output logic  o_idle,
    output t_done o_done
);

    localparam int IW = $clog2(ENTRIES + 1);
    localparam int CW = IW + 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_URD  = 4'd3;
    localparam logic [3:0] S_UWR  = 4'd4;
    localparam logic [3:0] S_QRD  = 4'd5;
    localparam logic [3:0] S_QACC = 4'd6;
    localparam logic [3:0] S_QMUL = 4'd7;
    localparam logic [3:0] S_QFIN = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_a, n_a;
    logic [CW-1:0]     r_b, n_b;
    logic [CW-1:0]     r_k, n_k;
    logic              r_phase, n_phase;
    logic              r_cmd, n_cmd;
    logic              r_has_res, n_has_res;
    logic [DATA_W-1:0] r_v, n_v;
    logic [DATA_W-1:0] r_d1, n_d1;
    logic [DATA_W-1:0] r_d2, n_d2;
    logic [DATA_W-1:0] r_s1, n_s1;
    logic [DATA_W-1:0] r_s2, n_s2;
    logic [DATA_W-1:0] r_prod, n_prod;
    logic [DATA_W-1:0] r_acc, n_acc;

    logic [IDX_W-1:0]  w_rc;
    logic              w_empty;
    logic [CW-1:0]     w_low;
    logic [CW-1:0]     w_up;
    logic [CW-1:0]     w_down;
    logic [DATA_W-1:0] w_mop;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_t;
    logic              w_we;
    logic [DATA_W-1:0] w_wd1, w_wd2;
    logic [DATA_W-1:0] w_rd1, w_rd2;
    logic              w_free;

    // right index saturates at the last element
    assign w_rc    = (32'(i_req.right) >= ENTRIES) ? IDX_W'(ENTRIES - 1) : i_req.right;
    assign w_empty = i_req.left > w_rc;

    assign w_low  = r_idx & (~r_idx + CW'(1));
    assign w_up   = r_idx + w_low;
    assign w_down = r_idx - w_low;

    // the one shared multiplier
    assign w_mop  = (r_cmd == CMD_ADD) ? r_v : r_s1;
    assign w_prod = DATA_W'(w_mop * DATA_W'(r_k));
    assign w_t    = r_prod - r_s2;

    assign w_free = !r_has_res || i_out_free;

    always_comb begin
        w_we  = 1'b0;
        w_wd1 = r_d1 + w_rd1;
        w_wd2 = r_d2 + w_rd2;
        if (r_state == S_CLR) begin
            w_we  = 1'b1;
            w_wd1 = '0;
            w_wd2 = '0;
        end else if (r_state == S_UWR) begin
            w_we = 1'b1;
        end
    end

    rast_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES + 1)) u_ram_lin (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (w_wd1),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rd1)
    );

    rast_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES + 1)) u_ram_ofs (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (w_wd2),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rd2)
    );

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_a       = r_a;
        n_b       = r_b;
        n_k       = r_k;
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_has_res = r_has_res;
        n_v       = r_v;
        n_d1      = r_d1;
        n_d2      = r_d2;
        n_s1      = r_s1;
        n_s2      = r_s2;
        n_prod    = r_prod;
        n_acc     = r_acc;
        case (r_state)
            S_CLR: begin
                n_idx = r_idx + CW'(1);
                if (r_idx == CW'(ENTRIES)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_req.cmd;
                    n_v       = i_req.value;
                    n_a       = CW'(i_req.left) + CW'(1);
                    n_b       = CW'(w_rc) + CW'(1);
                    n_phase   = 1'b0;
                    n_acc     = '0;
                    n_s1      = '0;
                    n_s2      = '0;
                    n_has_res = (i_req.cmd == CMD_SUM);
                    if (w_empty) begin
                        n_state = S_DONE;
                    end else if (i_req.cmd == CMD_ADD) begin
                        n_idx   = CW'(i_req.left) + CW'(1);
                        n_k     = CW'(i_req.left);
                        n_state = S_MUL;
                    end else begin
                        n_idx   = CW'(w_rc) + CW'(1);
                        n_k     = CW'(w_rc) + CW'(1);
                        n_state = S_QRD;
                    end
                end
            end
            S_MUL: begin
                // second update point carries the negated deltas
                n_d1    = r_phase ? -r_v : r_v;
                n_d2    = r_phase ? -w_prod : w_prod;
                n_state = S_URD;
            end
            S_URD: begin
                n_state = S_UWR;
            end
            S_UWR: begin
                if (w_up <= CW'(ENTRIES)) begin
                    n_idx   = w_up;
                    n_state = S_URD;
                end else if (!r_phase && r_b < CW'(ENTRIES)) begin
                    n_phase = 1'b1;
                    n_k     = r_b;
                    n_idx   = r_b + CW'(1);
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QRD: begin
                n_state = S_QACC;
            end
            S_QACC: begin
                n_s1  = r_s1 + w_rd1;
                n_s2  = r_s2 + w_rd2;
                n_idx = w_down;
                n_state = (w_down == '0) ? S_QMUL : S_QRD;
            end
            S_QMUL: begin
                n_prod  = w_prod;
                n_state = S_QFIN;
            end
            S_QFIN: begin
                // prefix total is s1 * p - s2
                if (!r_phase) begin
                    n_acc = w_t;
                    if (r_a == CW'(1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_phase = 1'b1;
                        n_idx   = r_a - CW'(1);
                        n_k     = r_a - CW'(1);
                        n_s1    = '0;
                        n_s2    = '0;
                        n_state = S_QRD;
                    end
                end else begin
                    n_acc   = r_acc - w_t;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_phase   <= 1'b0;
            r_cmd     <= CMD_ADD;
            r_has_res <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_has_res <= n_has_res;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_k    <= n_k;
        r_v    <= n_v;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
        r_s1   <= n_s1;
        r_s2   <= n_s2;
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_idle           = (r_state == S_IDLE);
    assign o_done.valid      = (r_state == S_DONE) && w_free;
    assign o_done.has_result = r_has_res;
    assign o_done.sum        = r_acc;

endmodule

/* hdl/range_add_range_sum_tree_top.sv */
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top
// range add and range sum over ENTRIES wrapping signed 32-bit counters
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries command, left and right index and
// add value; output channel o_valid/i_ready carries one range_sum per sum
// item, adds give no result. right index saturates at ENTRIES-1, an empty
// range adds nothing and sums to zero.
// counters are held as two binary indexed trees in ram; one sequencer walks
// the tree nodes with a read then write (add) or read then accumulate (sum)
// per node, and a single 32x32 multiplier forms the offset terms.
// the time an item takes is set by the two node walks, with a read state
// and a write or accumulate state per node; one item at a time.
// after reset a clearing pass over all ENTRIES+1 ram words zeroes the
// rams, o_ready stays low meanwhile.
// a result waits in the output register while i_ready is low; the next
// item is still taken, and only its own result waits for the register.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_top import rast_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_command,
    input  logic [IDX_W-1:0]         i_left_index,
    input  logic [IDX_W-1:0]         i_right_index,
    input  logic signed [DATA_W-1:0] i_add_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_range_sum
);

`include "range_add_range_sum_tree_top_assert.svh"

    t_req              w_req;
    t_done             w_done;
    logic              w_idle;
    logic              w_accept;
    logic              w_out_free;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_sum, n_out_sum;

    assign w_req.cmd   = i_command;
    assign w_req.left  = i_left_index;
    assign w_req.right = i_right_index;
    assign w_req.value = i_add_value;

    assign o_ready    = w_idle;
    assign w_accept   = i_valid && w_idle;
    assign w_out_free = !r_out_valid || i_ready;

    rast_core #(.ENTRIES(ENTRIES)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_req      (w_req),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_done     (w_done)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_done.valid && w_done.has_result) begin
            n_out_valid = 1'b1;
            n_out_sum   = w_done.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_sum <= n_out_sum;
    end

    assign o_valid     = r_out_valid;
    assign o_range_sum = r_out_sum;

    `RAST_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_ready, "ready after item accept")
    `RAST_ASSERT_IMPLY(a_no_overwrite, w_done.valid && w_done.has_result, w_out_free, "result overwrites held item")
    `RAST_ASSERT_IMPLY(a_done_not_idle, w_done.valid, !w_idle, "completion while idle")

endmodule
